>>> rtl/core/hsfc_pkg.sv
package hsfc_pkg;

   localparam int unsigned WARMUP_SECONDS_DEF = 1200;

   localparam logic [7:0]  CRC_INIT     = 8'hFF;
   localparam logic [7:0]  CRC_POLY     = 8'h31;
   localparam logic [14:0] T_SCALE      = 15'd17500;
   localparam logic [13:0] H_SCALE      = 14'd10000;
   localparam logic [14:0] T_BASE       = 15'd4500;
   localparam logic [14:0] T_MAX        = 15'd7000;
   localparam logic [11:0] OFFSET_RESET = 12'hE70;
   localparam int unsigned RECIP_SHIFT  = 28;
   localparam int unsigned PIPE_DEPTH   = 4;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_CRC   = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      REG_TEMP_OFFSET = 1'b0
   } reg_index_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
      logic [7:0] c;
      c = crc_in ^ data;
      for (int b = 0; b < 8; b++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/core/hsfc_if.sv
interface hsfc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] raw_temperature;
   logic [7:0]  temperature_crc;
   logic [15:0] raw_humidity;
   logic [7:0]  humidity_crc;
   logic [31:0] uptime_seconds;
   logic        cold_power_on;

   modport source(output valid, raw_temperature, temperature_crc, raw_humidity,
                  humidity_crc, uptime_seconds, cold_power_on, input ready);
   modport sink(input valid, raw_temperature, temperature_crc, raw_humidity,
                humidity_crc, uptime_seconds, cold_power_on, output ready);
endinterface

interface hsfc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [14:0] temperature_centi;
   logic [13:0]        humidity_centi;
   logic [1:0]         status;

   modport source(output valid, temperature_centi, humidity_centi, status, input ready);
   modport sink(input valid, temperature_centi, humidity_centi, status, output ready);
endinterface

>>> rtl/core/humidity_sensor_frame_convert.sv
// channel   | direction | handshake              | payload
// req_bus   | in        | valid/ready            | raw words, crc bytes, uptime, cold flag
// rsp_bus   | out       | valid/ready            | temperature, humidity, status
// csr       | in        | apb write, always ready | self-heating offset at byte 0
//
// one transaction per cycle sustained while rsp_bus is ready
// each result passes the crc and scaling stages and the warm-up reciprocal multiply
// reset is synchronous; clears valid bits and loads offset -400
// a stall on rsp_bus holds the stages that are full, empty stages keep filling
module humidity_sensor_frame_convert
   import hsfc_pkg::*;
#(
   parameter int unsigned WARMUP_SECONDS = WARMUP_SECONDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   hsfc_req_if.sink    req_bus,
   hsfc_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic signed [11:0] heat_offset;

   hsfc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .heat_offset (heat_offset)
   );

   hsfc_pipe #(
      .WARMUP_SECONDS (WARMUP_SECONDS)
   ) u_pipe (
      .clock       (clock),
      .reset       (reset),
      .heat_offset (heat_offset),
      .req         (req_bus),
      .rsp         (rsp_bus)
   );

endmodule

>>> rtl/core/hsfc_csr.sv
module hsfc_csr
   import hsfc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output logic signed [11:0] heat_offset
);

   logic [11:0]   offset_ff;
   logic [11:0]   offset_in;
   reg_index_type index;

   assign index  = reg_index_type'(paddr[2]);
   assign pready = 1'b1;

   always_comb begin
      offset_in = offset_ff;
      if (psel && penable && pwrite && index == REG_TEMP_OFFSET) begin
         offset_in = pwdata[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
      end else begin
         offset_ff <= offset_in;
      end
   end

   always_comb begin
      case (index)
         REG_TEMP_OFFSET: prdata = {{20{offset_ff[11]}}, offset_ff};
         default:         prdata = 32'd0;
      endcase
   end

   assign heat_offset = $signed(offset_ff);

endmodule

>>> rtl/core/hsfc_pipe.sv
module hsfc_pipe
   import hsfc_pkg::*;
#(
   parameter int unsigned WARMUP_SECONDS = WARMUP_SECONDS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [11:0] heat_offset,
   hsfc_req_if.sink           req,
   hsfc_rsp_if.source         rsp
);

   localparam logic [15:0] WARM_LIMIT = 16'(WARMUP_SECONDS);
   localparam logic [28:0] RECIP      = 29'((64'd1 << RECIP_SHIFT) / WARMUP_SECONDS);

   logic en1, en2, en3, en4;

   // stage 1: first crc byte, scaling products, warm-up product
   logic        v1_ff;
   logic [7:0]  crc_t1_ff, crc_h1_ff, t_lo1_ff, h_lo1_ff, tc1_ff, hc1_ff;
   logic [30:0] prod_t1_ff;
   logic [29:0] prod_h1_ff;
   logic [27:0] p1_ff;
   logic        warm1_ff, neg1_ff;
   logic [11:0] off1_ff;
   logic [11:0] off_mag;

   // stage 2: second crc byte, base subtraction, reciprocal multiply
   logic               v2_ff;
   logic               crc_ok2_ff;
   logic signed [14:0] t2_ff;
   logic [13:0]        h2_ff;
   logic [10:0]        q0_2_ff;
   logic [27:0]        p2_ff;
   logic               warm2_ff, neg2_ff;
   logic [11:0]        off2_ff;
   logic [56:0]        recip_prod;

   // stage 3: range check, remainder
   logic               v3_ff;
   logic               crc_ok3_ff, range3_ff;
   logic signed [14:0] t3_ff;
   logic [13:0]        h3_ff;
   logic [10:0]        q0_3_ff;
   logic [16:0]        r3_ff;
   logic               warm3_ff, neg3_ff;
   logic [11:0]        off3_ff;
   logic [26:0]        qw;
   logic [27:0]        r_full;

   // stage 4: output register
   logic               v4_ff;
   logic signed [14:0] t4_ff;
   logic [13:0]        h4_ff;
   status_type         st4_ff;
   logic [11:0]        q;
   logic signed [14:0] eff;
   logic signed [14:0] t4_in;
   logic [13:0]        h4_in;
   status_type         st4_in;

   assign en4       = !v4_ff || rsp.ready;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req.valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   assign off_mag = heat_offset[11] ? (~heat_offset + 12'd1) : heat_offset;

   always_ff @(posedge clock) begin
      if (en1) begin
         crc_t1_ff  <= crc8_byte(CRC_INIT, req.raw_temperature[15:8]);
         crc_h1_ff  <= crc8_byte(CRC_INIT, req.raw_humidity[15:8]);
         t_lo1_ff   <= req.raw_temperature[7:0];
         h_lo1_ff   <= req.raw_humidity[7:0];
         tc1_ff     <= req.temperature_crc;
         hc1_ff     <= req.humidity_crc;
         prod_t1_ff <= 31'(req.raw_temperature) * 31'(T_SCALE);
         prod_h1_ff <= 30'(req.raw_humidity) * 30'(H_SCALE);
         p1_ff      <= 28'(off_mag) * 28'(req.uptime_seconds[15:0]);
         warm1_ff   <= req.cold_power_on && (req.uptime_seconds < 32'(WARM_LIMIT));
         neg1_ff    <= heat_offset[11];
         off1_ff    <= heat_offset;
      end
   end

   assign recip_prod = 57'(p1_ff) * 57'(RECIP);

   always_ff @(posedge clock) begin
      if (en2) begin
         crc_ok2_ff <= (crc8_byte(crc_t1_ff, t_lo1_ff) == tc1_ff) &&
                       (crc8_byte(crc_h1_ff, h_lo1_ff) == hc1_ff);
         t2_ff      <= $signed(prod_t1_ff[30:16] - T_BASE);
         h2_ff      <= prod_h1_ff[29:16];
         q0_2_ff    <= recip_prod[RECIP_SHIFT +: 11];
         p2_ff      <= p1_ff;
         warm2_ff   <= warm1_ff;
         neg2_ff    <= neg1_ff;
         off2_ff    <= off1_ff;
      end
   end

   assign qw     = 27'(q0_2_ff) * 27'(WARM_LIMIT);
   assign r_full = p2_ff - 28'(qw);

   always_ff @(posedge clock) begin
      if (en3) begin
         crc_ok3_ff <= crc_ok2_ff;
         range3_ff  <= t2_ff[14] || (t2_ff > $signed(T_MAX));
         t3_ff      <= t2_ff;
         h3_ff      <= h2_ff;
         q0_3_ff    <= q0_2_ff;
         r3_ff      <= r_full[16:0];
         warm3_ff   <= warm2_ff;
         neg3_ff    <= neg2_ff;
         off3_ff    <= off2_ff;
      end
   end

   always_comb begin
      q = 12'(q0_3_ff) + ((r3_ff >= 17'(WARM_LIMIT)) ? 12'd1 : 12'd0);
      if (warm3_ff) begin
         eff = neg3_ff ? -$signed(15'(q)) : $signed(15'(q));
      end else begin
         eff = $signed({{3{off3_ff[11]}}, off3_ff});
      end
      if (!crc_ok3_ff) begin
         t4_in  = '0;
         h4_in  = '0;
         st4_in = STATUS_CRC;
      end else if (range3_ff) begin
         t4_in  = t3_ff;
         h4_in  = h3_ff;
         st4_in = STATUS_RANGE;
      end else begin
         t4_in  = t3_ff + eff;
         h4_in  = h3_ff;
         st4_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         t4_ff  <= t4_in;
         h4_ff  <= h4_in;
         st4_ff <= st4_in;
      end
   end

   assign rsp.valid             = v4_ff;
   assign rsp.temperature_centi = t4_ff;
   assign rsp.humidity_centi    = h4_ff;
   assign rsp.status            = st4_ff;

endmodule

>>> rtl/core/hsfc_checker.sv
module hsfc_checker
   import hsfc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [14:0] rsp_temperature,
   input logic [13:0] rsp_humidity,
   input logic [1:0]  rsp_status
);

   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       in_acc, out_acc;

   assign in_acc  = req_valid && req_ready;
   assign out_acc = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (in_acc && !out_acc) pending_in = pending_ff + 3'd1;
      if (!in_acc && out_acc) pending_in = pending_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'(PIPE_DEPTH))
      else $error("more transactions in flight than pipeline stages");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("result without an accepted transaction");

   a_crc_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_CRC) |-> (rsp_temperature == '0 && rsp_humidity == '0))
      else $error("crc failure with nonzero fields");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind humidity_sensor_frame_convert hsfc_checker u_hsfc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_temperature (rsp_bus.temperature_centi),
   .rsp_humidity    (rsp_bus.humidity_centi),
   .rsp_status      (rsp_bus.status)
);
